FILE: hdl/positional_insert_delete_array_macros.svh
// assertion macros for the block's top module
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_MACROS_SVH

// same-cycle implication, checked out of reset
`define PIDA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define PIDA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/pida_pkg.sv
// ----------------------------------------------------------------------------
// pida_pkg
// Types and constants for the positional insert/delete array.
// ----------------------------------------------------------------------------
package pida_pkg;

	// default number of entries
	localparam int DEF_CAPACITY = 128;
	// index/count width of the cell broadcast, covers capacities up to 2047
	localparam int IDX_W = 11;
	// cells per first-level group of the removed-value select
	localparam int PICK_GROUP = 32;
	localparam int VAL_W = 32;

	// command codes
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_DELETE = 1'b1;

	// status codes
	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_EMPTY  = 2'd2;
	localparam logic [1:0] ST_BADPOS = 2'd3;

	typedef logic [VAL_W-1:0] word_t;

	typedef struct packed {
		logic               command;
		logic [6:0]         position;
		logic signed [31:0] element_value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed_value;
		logic [7:0]         entry_count;
	} rsp_t;

	// operation broadcast to every cell
	typedef struct packed {
		logic             ins_ok;
		logic             del_ok;
		logic [IDX_W-1:0] pos;
		logic [IDX_W-1:0] count;
		word_t            value;
	} bcast_t;

endpackage

FILE: hdl/pida_cell.sv
// ----------------------------------------------------------------------------
// pida_cell
// One array slot: loads the new value, its left or its right neighbor.
// ----------------------------------------------------------------------------
module pida_cell #(
	parameter int IDX = 0
) (
	input  logic            clk,
	input  pida_pkg::bcast_t op,
	input  pida_pkg::word_t  left,
	input  pida_pkg::word_t  right,
	output pida_pkg::word_t  entry_q,
	output pida_pkg::word_t  pick
);
	import pida_pkg::*;

	localparam logic [IDX_W-1:0] ME = IDX_W'(IDX);

	logic at_pos;
	logic take_left;
	logic take_right;

	// position compares against this slot
	assign at_pos     = (ME == op.pos);
	assign take_left  = op.ins_ok && (ME > op.pos) && (ME <= op.count);
	assign take_right = op.del_ok && (ME >= op.pos) && ((ME + IDX_W'(1)) < op.count);

	// slot update, contents undefined until written
	always_ff @(posedge clk) begin
		priority if (op.ins_ok && at_pos) begin
			entry_q <= op.value;
		end else if (take_left) begin
			entry_q <= left;
		end else if (take_right) begin
			entry_q <= right;
		end else begin
			entry_q <= entry_q;
		end
	end

	// old contents offered to the removed-value select
	assign pick = (op.del_ok && at_pos) ? entry_q : '0;

endmodule

FILE: hdl/pida_or_stage.sv
// ----------------------------------------------------------------------------
// pida_or_stage
// Registered OR reduction over groups of words; at most one is non-zero.
// ----------------------------------------------------------------------------
module pida_or_stage #(
	parameter int GROUPS = 1,
	parameter int WIDTH  = 2
) (
	input  logic                                  clk,
	input  logic                                  en,
	input  pida_pkg::word_t [GROUPS*WIDTH-1:0]    din,
	output pida_pkg::word_t [GROUPS-1:0]          dout_q
);
	import pida_pkg::*;

	word_t [GROUPS-1:0] red;

	// per-group reduction
	always_comb begin
		for (int g = 0; g < GROUPS; g++) begin
			red[g] = '0;
			for (int k = 0; k < WIDTH; k++) begin
				red[g] = red[g] | din[g*WIDTH + k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout_q <= red;
		end
	end

endmodule

FILE: hdl/positional_insert_delete_array.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_array
// Ordered array with insert/delete at a position, built as a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one command per transfer:
//   insert element_value at position, or delete the entry at position.
//   rsp channel (rsp_valid/rsp_ready/rsp) returns one result per command:
//   status, removed value (zero unless a delete succeeds), count after it.
//   Each result passes one stage register and one output register on its
//   way from the command transfer to the result transfer.
//   Throughput: one command per cycle while rsp_ready keeps up. Every cell
//   shifts in the cycle of the transfer, so the next command sees the updated
//   array at once; the removed value goes through a two-level registered select.
//   Reset clears the count and the pipeline valids; cell contents stay
//   undefined until written and are never read below an unwritten slot.
//   When rsp_ready is low with a result waiting, the pipeline holds and
//   cmd_ready drops until the waiting result is taken.
// ----------------------------------------------------------------------------
module positional_insert_delete_array #(
	parameter int CAPACITY = pida_pkg::DEF_CAPACITY
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  pida_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output pida_pkg::rsp_t rsp
);
	import pida_pkg::*;

	`include "positional_insert_delete_array_macros.svh"

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int XW   = (CW > 8) ? CW : 8;
	localparam int NGRP = (CAPACITY + PICK_GROUP - 1) / PICK_GROUP;

	logic          adv;
	logic          acc;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	logic [XW-1:0] count_x;
	logic [1:0]    status;
	logic          ins_ok;
	logic          del_ok;
	logic [IDX_W-1:0] pos_x;
	logic [IDX_W-1:0] cnt_x;
	bcast_t        op;

	logic          valid_s1;
	logic [1:0]    status_s1;
	logic [7:0]    count_s1;
	logic          rsp_valid_q;
	logic [1:0]    status_q;
	logic [7:0]    rsp_count_q;

	word_t [CAPACITY-1:0]        entry;
	word_t [NGRP*PICK_GROUP-1:0] pick_all;
	word_t [NGRP-1:0]            grp_s1;
	word_t [0:0]                 removed_q;

	// handshake: the pipeline moves when the output slot is free or taken
	assign adv       = !rsp_valid_q || rsp_ready;
	assign cmd_ready = adv;
	assign acc       = cmd_valid && adv;

	assign pos_x = IDX_W'(cmd.position);
	assign cnt_x = IDX_W'(count_q);

	// command check against the current count
	always_comb begin
		ins_ok = 1'b0;
		del_ok = 1'b0;
		status = ST_DONE;
		unique case (cmd.command)
			CMD_INSERT: begin
				priority if (count_q == CW'(CAPACITY)) begin
					status = ST_FULL;
				end else if (pos_x > cnt_x) begin
					status = ST_BADPOS;
				end else begin
					ins_ok = acc;
				end
			end
			CMD_DELETE: begin
				priority if (count_q == '0) begin
					status = ST_EMPTY;
				end else if (pos_x >= cnt_x) begin
					status = ST_BADPOS;
				end else begin
					del_ok = acc;
				end
			end
		endcase
	end

	// count after the command
	always_comb begin
		priority if (ins_ok) begin
			count_nxt = count_q + CW'(1);
		end else if (del_ok) begin
			count_nxt = count_q - CW'(1);
		end else begin
			count_nxt = count_q;
		end
	end
	assign count_x = XW'(count_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	// broadcast to the cell row
	assign op.ins_ok = ins_ok;
	assign op.del_ok = del_ok;
	assign op.pos    = pos_x;
	assign op.count  = cnt_x;
	assign op.value  = word_t'(cmd.element_value);

	// row of cells, each wired to both neighbors
	for (genvar i = 0; i < NGRP * PICK_GROUP; i++) begin : g_cell
		if (i < CAPACITY) begin : g_used
			word_t left_w;
			word_t right_w;
			if (i == 0) begin : g_first
				assign left_w = '0;
			end else begin : g_mid_l
				assign left_w = entry[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign right_w = '0;
			end else begin : g_mid_r
				assign right_w = entry[i+1];
			end
			pida_cell #(
				.IDX(i)
			) u_cell (
				.clk    (clk),
				.op     (op),
				.left   (left_w),
				.right  (right_w),
				.entry_q(entry[i]),
				.pick   (pick_all[i])
			);
		end else begin : g_pad
			assign pick_all[i] = '0;
		end
	end

	// removed-value select, first level
	pida_or_stage #(
		.GROUPS(NGRP),
		.WIDTH (PICK_GROUP)
	) u_sel_s1 (
		.clk   (clk),
		.en    (adv),
		.din   (pick_all),
		.dout_q(grp_s1)
	);

	// removed-value select, second level into the output register
	pida_or_stage #(
		.GROUPS(1),
		.WIDTH (NGRP)
	) u_sel_out (
		.clk   (clk),
		.en    (adv),
		.din   (grp_s1),
		.dout_q(removed_q)
	);

	// result pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= acc;
			rsp_valid_q <= valid_s1;
		end
	end

	// result pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			status_s1   <= status;
			count_s1    <= count_x[7:0];
			status_q    <= status_s1;
			rsp_count_q <= count_s1;
		end
	end

	assign rsp_valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.removed_value = removed_q[0];
	assign rsp.entry_count   = rsp_count_q;

	// checks
	`PIDA_ASSERT_NOW(a_count_max, 1'b1, count_q <= CW'(CAPACITY), "count above capacity")
	`PIDA_ASSERT_NEXT(a_ins_count, ins_ok, count_q == $past(count_q) + CW'(1), "insert count")
	`PIDA_ASSERT_NEXT(a_refused_hold, acc && !ins_ok && !del_ok, $stable(count_q), "refused count")
	`PIDA_ASSERT_NOW(a_removed_zero, rsp_valid_q && (status_q != ST_DONE), removed_q[0] == '0, "removed not zero")

endmodule
